/* design/cbct_pkg.sv */
package cbct_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;

  localparam int POS_W    = 32;
  localparam int BLK_W    = 8;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = 7;
  localparam int KEY_W    = 3 * POS_W;
  localparam int RAM_W    = KEY_W + BLK_W;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_ADDED    = 3'd0;
  localparam status_t ST_UPDATED  = 3'd1;
  localparam status_t ST_REVERTED = 3'd2;
  localparam status_t ST_DROPPED  = 3'd3;
  localparam status_t ST_QHIT     = 3'd4;
  localparam status_t ST_QMISS    = 3'd5;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // compare results on the entry just read from the table
  typedef struct packed {
    logic key_eq;
    logic orig_eq;
  } cmp_t;

  typedef struct packed {
    status_t status;
    logic    modified;
    logic    notify;
  } res_t;

endpackage

/* design/cbct_ram.sv */
module cbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/cbct_ctrl.sv */
module cbct_ctrl import cbct_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept_i,
  input  logic             cmd_i,
  input  cmp_t             cmp_i,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [IDX_W-1:0] rd_addr_o,
  output logic             wr_en_o,
  output logic [IDX_W-1:0] wr_addr_o,
  output logic             done_o,
  output res_t             res_o,
  output logic [CNT_W-1:0] total_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic                     state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     issue_done_r, issue_done_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]         total_r, total_nxt;

  logic             hit;
  logic             decide;
  logic             have_free;
  logic [IDX_W-1:0] free_slot;

  assign hit       = rd_pend_r && valid_r[rd_idx_r] && cmp_i.key_eq;
  assign decide    = (state_r == S_SCAN) && rd_pend_r && (hit || rd_idx_r == LAST_IDX);
  assign have_free = free_found_r || !valid_r[rd_idx_r];
  assign free_slot = free_found_r ? free_idx_r : rd_idx_r;

  assign busy_o    = (state_r != S_IDLE);
  assign rd_en_o   = (state_r == S_SCAN) && !issue_done_r;
  assign rd_addr_o = idx_r;
  assign wr_en_o   = decide && (cmd_i == CMD_RECORD) && !hit && have_free;
  assign wr_addr_o = free_slot;
  assign done_o    = decide;
  assign total_o   = total_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    total_nxt      = total_r;
    res_o          = '{status: ST_QMISS, modified: 1'b0, notify: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (accept_i) begin
          state_nxt      = S_SCAN;
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          free_found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (!issue_done_r) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = idx_r;
          if (idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        // lowest free slot seen so far
        if (rd_pend_r && !valid_r[rd_idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = rd_idx_r;
        end
        if (decide) begin
          state_nxt   = S_IDLE;
          rd_pend_nxt = 1'b0;
          if (cmd_i == CMD_QUERY) begin
            res_o.status   = hit ? ST_QHIT : ST_QMISS;
            res_o.modified = hit;
          end else begin
            res_o.notify = 1'b1;
            if (hit) begin
              if (cmp_i.orig_eq) begin
                valid_nxt[rd_idx_r] = 1'b0;
                total_nxt           = total_r - CNT_W'(1);
                res_o.status        = ST_REVERTED;
              end else begin
                res_o.status   = ST_UPDATED;
                res_o.modified = 1'b1;
              end
            end else if (have_free) begin
              valid_nxt[free_slot] = 1'b1;
              total_nxt            = total_r + CNT_W'(1);
              res_o.status         = ST_ADDED;
              res_o.modified       = 1'b1;
            end else begin
              res_o.status = ST_DROPPED;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      rd_idx_r     <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      valid_r      <= '0;
      total_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      issue_done_r <= issue_done_nxt;
      rd_pend_r    <= rd_pend_nxt;
      rd_idx_r     <= rd_idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      valid_r      <= valid_nxt;
      total_r      <= total_nxt;
    end
  end

  a_total_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == CNT_W'($countones(valid_r)))
    else $error("entry count out of step with valid bits");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count above table size");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_o |=> (state_r == S_IDLE))
    else $error("scan did not end after result");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_i && state_r == S_IDLE) |=> (state_r == S_SCAN && !rd_pend_r))
    else $error("scan did not start cleanly");

  a_no_write_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_o |-> (cmd_i == CMD_RECORD && !hit))
    else $error("table write outside a record miss");

endmodule

/* design/coalescing_block_change_table_top.sv */
// Change table for up to TABLE_ENTRIES voxel positions. Assert start with a
// command; it is taken when busy is low. The table is searched one entry per
// cycle through a single-port-read memory, so a record or query that matches
// an entry returns its result once that entry has been read, and a miss
// returns it once the whole table has been read. busy stays high until the
// result is out. The result is shown for exactly one cycle with out_strobe
// and cannot be held off; out_entry_total stays valid until the next result.
module coalescing_block_change_table_top import cbct_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_command,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic [BLK_W-1:0]        in_prior_block,
  input  logic [BLK_W-1:0]        in_new_block,
  output logic                    out_strobe,
  output logic [STATUS_W-1:0]     out_status,
  output logic                    out_is_modified,
  output logic                    out_notify,
  output logic [ENTRY_W-1:0]      out_entry_total
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [BLK_W-1:0] prior_r;
  logic [BLK_W-1:0] new_r;

  logic             accept;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [RAM_W-1:0] rd_data;
  cmp_t             cmp;
  logic             done;
  res_t             res;
  logic [CNT_W-1:0] total;

  logic                strobe_r;
  res_t                res_r;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_command;
      key_r   <= {$unsigned(in_pos_x), $unsigned(in_pos_y), $unsigned(in_pos_z)};
      prior_r <= in_prior_block;
      new_r   <= in_new_block;
    end
  end

  // entry word: position key above original id
  assign cmp.key_eq  = (rd_data[RAM_W-1 -: KEY_W] == key_r);
  assign cmp.orig_eq = (rd_data[BLK_W-1:0] == new_r);

  cbct_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({key_r, prior_r}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  cbct_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .cmd_i     (cmd_r),
    .cmp_i     (cmp),
    .busy_o    (busy),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .done_o    (done),
    .res_o     (res),
    .total_o   (total)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_status      = res_r.status;
  assign out_is_modified = res_r.modified;
  assign out_notify      = res_r.notify;
  assign out_entry_total = ENTRY_W'(total);

endmodule

/* tb/coalescing_block_change_table_top_tb.sv */
module coalescing_block_change_table_top_tb import cbct_pkg::*; ();

  localparam int SLOTS       = DEF_TABLE_ENTRIES;
  localparam int POOL_SIZE   = 100;
  localparam int RAND_ITEMS  = 1750;
  localparam int SEGMENT_LEN = 250;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = SLOTS + 8;

  typedef struct {
    status_t            status;
    logic               modified;
    logic               notify;
    logic [ENTRY_W-1:0] total;
  } table_result_t;

  // shadow of the change table plus the results still owed by the block
  class change_table_sb;
    bit               valid [SLOTS];
    bit [POS_W-1:0]   sx [SLOTS];
    bit [POS_W-1:0]   sy [SLOTS];
    bit [POS_W-1:0]   sz [SLOTS];
    bit [BLK_W-1:0]   orig [SLOTS];
    bit [BLK_W-1:0]   cur [SLOTS];
    int               total;
    table_result_t    expected_q [$];
    int               errors;

    function new();
      foreach (valid[i]) valid[i] = 1'b0;
      total  = 0;
      errors = 0;
    endfunction

    function int lookup(bit [POS_W-1:0] x, bit [POS_W-1:0] y, bit [POS_W-1:0] z);
      for (int i = 0; i < SLOTS; i++)
        if (valid[i] && sx[i] == x && sy[i] == y && sz[i] == z) return i;
      return -1;
    endfunction

    function int pick_valid_slot();
      int live [$];
      for (int i = 0; i < SLOTS; i++)
        if (valid[i]) live.push_back(i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function void note_input(logic cmd, bit [POS_W-1:0] x, bit [POS_W-1:0] y,
                             bit [POS_W-1:0] z, bit [BLK_W-1:0] prior,
                             bit [BLK_W-1:0] next);
      int            hit;
      int            free_idx;
      table_result_t r;
      hit      = lookup(x, y, z);
      free_idx = -1;
      r.notify = (cmd == CMD_RECORD);
      if (cmd == CMD_QUERY) begin
        r.status   = (hit >= 0) ? ST_QHIT : ST_QMISS;
        r.modified = (hit >= 0);
      end else if (hit >= 0) begin
        cur[hit] = next;
        if (orig[hit] == next) begin
          valid[hit] = 1'b0;
          total--;
          r.status   = ST_REVERTED;
          r.modified = 1'b0;
        end else begin
          r.status   = ST_UPDATED;
          r.modified = 1'b1;
        end
      end else begin
        for (int i = 0; i < SLOTS; i++)
          if (!valid[i]) begin
            free_idx = i;
            break;
          end
        if (free_idx >= 0) begin
          valid[free_idx] = 1'b1;
          sx[free_idx]    = x;
          sy[free_idx]    = y;
          sz[free_idx]    = z;
          orig[free_idx]  = prior;
          cur[free_idx]   = next;
          total++;
          r.status   = ST_ADDED;
          r.modified = 1'b1;
        end else begin
          r.status   = ST_DROPPED;
          r.modified = 1'b0;
        end
      end
      r.total = ENTRY_W'(total);
      expected_q.push_back(r);
    endfunction

    function void check_result(status_t st, logic md, logic nt, logic [ENTRY_W-1:0] tot);
      table_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: status=%0d modified=%0b notify=%0b total=%0d",
                   st, md, nt, tot);
        return;
      end
      want = expected_q.pop_front();
      if (want.status !== st || want.modified !== md || want.notify !== nt ||
          want.total !== tot) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected status=%0d modified=%0b notify=%0b total=%0d,",
                    " got status=%0d modified=%0b notify=%0b total=%0d"},
                   want.status, want.modified, want.notify, want.total, st, md, nt, tot);
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n          = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic                    in_command     = CMD_RECORD;
  logic signed [POS_W-1:0] in_pos_x       = '0;
  logic signed [POS_W-1:0] in_pos_y       = '0;
  logic signed [POS_W-1:0] in_pos_z       = '0;
  logic [BLK_W-1:0]        in_prior_block = '0;
  logic [BLK_W-1:0]        in_new_block   = '0;
  logic                    out_strobe;
  logic [STATUS_W-1:0]     out_status;
  logic                    out_is_modified;
  logic                    out_notify;
  logic [ENTRY_W-1:0]      out_entry_total;

  change_table_sb  sb;
  int              next_gap = 0;
  bit              idle_on  = 1'b0;
  int              idle_cycles = 0;
  bit [POS_W-1:0]  pool_x [POOL_SIZE];
  bit [POS_W-1:0]  pool_y [POOL_SIZE];
  bit [POS_W-1:0]  pool_z [POOL_SIZE];

  coalescing_block_change_table_top #(
    .TABLE_ENTRIES(SLOTS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_prior_block (in_prior_block),
    .in_new_block   (in_new_block),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_is_modified(out_is_modified),
    .out_notify     (out_notify),
    .out_entry_total(out_entry_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result checking and watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(status_t'(out_status), out_is_modified, out_notify, out_entry_total);
    if ((start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // start stays high across back-to-back beats, lowered only when a gap follows
  task automatic drive_item(logic cmd, bit [POS_W-1:0] x, bit [POS_W-1:0] y,
                            bit [POS_W-1:0] z, bit [BLK_W-1:0] prior,
                            bit [BLK_W-1:0] next);
    repeat (next_gap) @(posedge clk);
    start          <= 1'b1;
    in_command     <= cmd;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_pos_z       <= z;
    in_prior_block <= prior;
    in_new_block   <= next;
    do @(posedge clk); while (busy);
    sb.note_input(cmd, x, y, z, prior, next);
    next_gap = idle_on ? $urandom_range(0, 4) : 0;
    if (next_gap != 0) start <= 1'b0;
  endtask

  task automatic run_random();
    int             mode;
    int             sel;
    int             slot;
    int             bit_idx;
    logic           cmd;
    bit [POS_W-1:0] x, y, z;
    bit [BLK_W-1:0] prior, next;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // small pool, large pool that overflows the table, then a draining phase
      mode = (n / SEGMENT_LEN) % 3;
      if (n % SEGMENT_LEN == 0) idle_on = ($urandom_range(0, 3) != 0);
      cmd   = ($urandom_range(0, 99) < 25) ? CMD_QUERY : CMD_RECORD;
      prior = BLK_W'($urandom_range(0, 255));
      next  = BLK_W'($urandom_range(0, 255));
      slot  = (mode == 2) ? sb.pick_valid_slot() : -1;
      if (mode == 2 && cmd == CMD_RECORD && slot >= 0 && $urandom_range(0, 99) < 80) begin
        x    = sb.sx[slot];
        y    = sb.sy[slot];
        z    = sb.sz[slot];
        next = sb.orig[slot];
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          x = $urandom;
          y = $urandom;
          z = $urandom;
        end else begin
          sel = $urandom_range(0, (mode == 0) ? 29 : POOL_SIZE - 1);
          x = pool_x[sel];
          y = pool_y[sel];
          z = pool_z[sel];
          // near miss: one bit off a known position
          if ($urandom_range(0, 99) < 7) begin
            bit_idx = $urandom_range(0, POS_W - 1);
            case ($urandom_range(0, 2))
              0: x[bit_idx] = ~x[bit_idx];
              1: y[bit_idx] = ~y[bit_idx];
              default: z[bit_idx] = ~z[bit_idx];
            endcase
          end
        end
        slot = sb.lookup(x, y, z);
        if (cmd == CMD_RECORD && slot >= 0 && $urandom_range(0, 2) == 0)
          next = sb.orig[slot];
      end
      drive_item(cmd, x, y, z, prior, next);
    end
  endtask

  initial begin
    sb = new();
    pool_x[0] = 32'h0000_0000; pool_y[0] = 32'h0000_0000; pool_z[0] = 32'h0000_0000;
    pool_x[1] = 32'h7fff_ffff; pool_y[1] = 32'h8000_0000; pool_z[1] = 32'hffff_ffff;
    pool_x[2] = 32'h8000_0000; pool_y[2] = 32'h7fff_ffff; pool_z[2] = 32'h0000_0000;
    pool_x[3] = 32'hffff_ffff; pool_y[3] = 32'hffff_ffff; pool_z[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) begin
        pool_x[i] = $urandom;
        pool_y[i] = $urandom;
        pool_z[i] = $urandom;
      end else begin
        // positions around chunk boundaries
        pool_x[i] = $urandom_range(0, 80) - 40;
        pool_y[i] = $urandom_range(0, 80) - 40;
        pool_z[i] = $urandom_range(0, 80) - 40;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    // miss with equal ids still adds, then a record with the same new id reverts it
    drive_item(CMD_RECORD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
    drive_item(CMD_QUERY,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'hff, 8'hff);
    drive_item(CMD_RECORD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h77, 8'h00);
    drive_item(CMD_QUERY,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
    drive_item(CMD_RECORD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'hff, 8'h01);
    drive_item(CMD_RECORD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'h00, 8'h02);
    drive_item(CMD_RECORD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'h00, 8'hff);
    drive_item(CMD_QUERY,  32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 8'h00, 8'h00);
    drive_item(CMD_RECORD, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 8'h12, 8'h34);
    drive_item(CMD_QUERY,  32'h8000_0001, 32'h7fff_ffff, 32'h0000_0000, 8'h00, 8'h00);
    drive_item(CMD_QUERY,  32'h8000_0000, 32'h7fff_fffe, 32'h0000_0000, 8'h00, 8'h00);
    drive_item(CMD_QUERY,  32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 8'h00, 8'h00);
    drive_item(CMD_QUERY,  32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 8'hff, 8'h12);
    idle_on = 1'b0;
    drive_item(CMD_RECORD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'haa, 8'h55);
    // prior id is ignored on a hit
    drive_item(CMD_RECORD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 8'h55, 8'haa);
    drive_item(CMD_RECORD, 32'h0000_000f, 32'hffff_fff0, 32'h0000_0010, 8'h03, 8'h04);
    drive_item(CMD_RECORD, 32'hffff_ffff, 32'h0000_0010, 32'hffff_fff1, 8'h05, 8'h06);
    drive_item(CMD_QUERY,  32'h0000_000f, 32'hffff_fff0, 32'h0000_0010, 8'h00, 8'h00);
    drive_item(CMD_RECORD, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 8'h00, 8'h12);
    drive_item(CMD_QUERY,  32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 8'h00, 8'h00);

    run_random();

    if (next_gap == 0) start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cbct_pkg.sv
design/cbct_ram.sv
design/cbct_ctrl.sv
design/coalescing_block_change_table_top.sv
tb/coalescing_block_change_table_top_tb.sv
